### rtl/sds_pkg.sv
package sds_pkg;

    localparam int CoordW = 24;
    localparam int PresW  = 12;
    localparam int RegW   = 16;
    localparam int DeltaW = 25;
    localparam int SqW    = 50;
    localparam int LenW   = 25;
    localparam int OffW   = 17;
    localparam int FullPressure = 2048;

    localparam logic [0:0] RegPenWidth = 1'b0;
    localparam logic [0:0] RegDabStep  = 1'b1;

    // divider request: unsigned numerator over unsigned denominator
    // numerator holds |delta| * distance + len / 2, up to 49 bits
    localparam int NumW = 49;
    localparam int DenW = 25;

    typedef struct packed {
        logic            start;
        logic [NumW-1:0] num;
        logic [DenW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [NumW-1:0] quo;
        logic [DenW-1:0] rem;
    } t_div_rsp;

endpackage

### rtl/stroke_dab_spacer_unit.sv
// stroke dab spacer
// input channel: one polyline point word (x, y, pressure, new_stroke, visible)
// per valid/ready handshake; output channel: one dab word per handshake
// config port: i_cfg_we with i_cfg_idx 0 = pen_width, 1 = dab_step
// every point after the first of a stroke ends a segment; the segment length
// comes from a bit-serial square root, the dab count from a restoring
// divider, then each dab needs three divisions (x, y, pressure) on the
// same divider before its output load
// a stroke start point is only stored; a segment point runs the square root,
// then all its divisions one at a time on the shared divider
// up to MAX_DABS dabs are emitted per point, the last one flagged
// reset clears the stored point and offset; the next point starts a stroke
// a stalled receiver holds the dab word in the output register and the
// sequencer waits; no new point is taken until all dabs of one are taken
module stroke_dab_spacer_unit
    import sds_pkg::*;
#(
    parameter int MAX_DABS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [0:0]               i_cfg_idx,
    input  logic [RegW-1:0]          i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [CoordW-1:0] i_point_x,
    input  logic signed [CoordW-1:0] i_point_y,
    input  logic [PresW-1:0]         i_point_pressure,
    input  logic                     i_new_stroke,
    input  logic                     i_visible,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [CoordW-1:0] o_dab_x,
    output logic signed [CoordW-1:0] o_dab_y,
    output logic [14:0]              o_dab_radius,
    output logic [7:0]               o_dab_alpha,
    output logic                     o_last_dab,
    output logic                     o_dabs_truncated
);
    localparam int KW = $clog2(MAX_DABS + 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SQRT   = 9'b000000010,
        S_CNT    = 9'b000000100,
        S_DIVX   = 9'b000001000,
        S_DIVY   = 9'b000010000,
        S_DIVP   = 9'b000100000,
        S_ATTR   = 9'b001000000,
        S_OUT    = 9'b010000000,
        S_WAIT   = 9'b100000000
    } t_state_e;

    t_state_e r_state, n_state;

    // configuration
    logic [RegW-1:0] r_pen_width, r_dab_step;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_width <= 16'd256;
            r_dab_step  <= 16'd26;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegPenWidth: r_pen_width <= i_cfg_data;
                RegDabStep:  r_dab_step  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stroke state
    logic signed [CoordW-1:0] r_prev_x, r_prev_y;
    logic [PresW-1:0]         r_prev_p;
    logic [OffW-1:0]          r_offset;
    logic                     r_have_prev;

    // segment working registers
    logic signed [DeltaW-1:0] r_dx, r_dy;
    logic signed [PresW:0]    r_dp;
    logic [LenW-1:0]          r_len;
    logic [RegW-1:0]          r_step;
    logic [LenW:0]            r_d;
    logic [KW-1:0]            r_k, r_emit;
    logic                     r_trunc, r_vis, r_go;
    logic signed [CoordW-1:0] r_cur_x, r_cur_y, r_new_x, r_new_y;
    logic [PresW-1:0]         r_cur_p, r_new_p, r_pp;
    logic                     r_neg;

    // output register
    logic signed [CoordW-1:0] r_ox, r_oy;
    logic [14:0]              r_orad;
    logic [7:0]               r_oal;
    logic                     r_olast, r_otr, r_ovalid;

    // shared units
    logic            w_sq_start, w_sq_done;
    logic [SqW-1:0]  w_sq_val;
    logic [LenW-1:0] w_root;
    t_div_req        r_req;
    t_div_rsp        w_rsp;

    sds_sqrt u_sqrt (.i_clk, .i_rst_n, .i_start(w_sq_start), .i_val(w_sq_val),
                     .o_done(w_sq_done), .o_root(w_root));
    sds_div  u_div  (.i_clk, .i_rst_n, .i_req(r_req), .o_rsp(w_rsp));

    logic w_in_acc;
    assign w_in_acc = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE) && !r_ovalid;

    logic [PresW-1:0] w_pin;
    assign w_pin = (i_point_pressure > PresW'(FullPressure)) ? PresW'(FullPressure)
                                                             : i_point_pressure;

    // dx, dy squared: one multiplier reused, dx first, then dy
    logic signed [DeltaW-1:0] w_mul_in;
    logic signed [SqW-1:0]    w_mul_ext;
    logic [SqW-1:0]           w_mul_out, r_sqsum;
    logic                     r_sqph;
    assign w_mul_in  = r_sqph ? r_dy : r_dx;
    assign w_mul_ext = SqW'(w_mul_in);
    assign w_mul_out = $unsigned(w_mul_ext * w_mul_ext);

    // current interpolation magnitude
    logic signed [DeltaW-1:0] w_delta;
    logic [DeltaW-1:0]        w_mag;
    logic [NumW-1:0]          w_prod;
    always_comb begin
        case (r_state)
            S_DIVY:  w_delta = r_dy;
            S_DIVP:  w_delta = DeltaW'(r_dp);
            default: w_delta = r_dx;
        endcase
    end
    assign w_mag  = w_delta[DeltaW-1] ? DeltaW'(-w_delta) : w_delta;
    assign w_prod = NumW'(w_mag) * NumW'(r_d) + NumW'(r_len >> 1);

    logic signed [CoordW:0] w_rq;
    assign w_rq = r_neg ? -$signed({1'b0, w_rsp.quo[CoordW-1:0]})
                        :  $signed({1'b0, w_rsp.quo[CoordW-1:0]});

    logic [27:0] w_rad_prod;
    logic [19:0] w_al_prod;
    assign w_rad_prod = 28'(r_pen_width) * (28'(FullPressure) + 28'(r_pp));
    assign w_al_prod  = 20'(r_pp) * 20'd255;

    logic [1:0] r_ph;

    // divider launches: dab count after the root, one per interpolation
    logic w_cnt_fire, w_div_fire, w_out_load;
    assign w_cnt_fire = (r_state == S_SQRT) && (r_ph == 2'd3) && w_sq_done &&
                        (w_root != '0) && ({8'd0, r_offset} <= w_root);
    assign w_div_fire = (r_state inside {S_DIVX, S_DIVY, S_DIVP}) && !r_go;
    assign w_out_load = (r_state == S_OUT) && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_have_prev <= 1'b0; r_offset <= '0;
            r_prev_x <= '0; r_prev_y <= '0; r_prev_p <= '0; r_ovalid <= 1'b0;
            r_ph <= '0; r_sqph <= 1'b0; r_k <= '0;
            r_req.start <= 1'b0;
        end else begin
            r_req.start <= w_cnt_fire || w_div_fire;
            if (w_out_load) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (w_in_acc) begin
                    r_new_x <= i_point_x; r_new_y <= i_point_y; r_new_p <= w_pin;
                    r_vis <= i_visible;
                    if (i_new_stroke || !r_have_prev) begin
                        r_prev_x <= i_point_x; r_prev_y <= i_point_y;
                        r_prev_p <= w_pin; r_offset <= '0; r_have_prev <= 1'b1;
                    end else begin
                        r_dx <= DeltaW'(i_point_x) - DeltaW'(r_prev_x);
                        r_dy <= DeltaW'(i_point_y) - DeltaW'(r_prev_y);
                        r_dp <= $signed({1'b0, w_pin}) - $signed({1'b0, r_prev_p});
                        r_step <= (r_dab_step == '0) ? 16'd1 : r_dab_step;
                        r_sqph <= 1'b0; r_ph <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_ph == 2'd0) begin
                        r_sqsum <= w_mul_out; r_sqph <= 1'b1; r_ph <= 2'd1;
                    end else if (r_ph == 2'd1) begin
                        r_sqsum <= r_sqsum + w_mul_out; r_ph <= 2'd2;
                    end else if (r_ph == 2'd2) begin
                        r_ph <= 2'd3;
                    end else if (w_sq_done) begin
                        r_len <= w_root; r_ph <= '0;
                        if (w_root == '0) begin
                            r_state <= S_WAIT;
                        end else if ({8'd0, r_offset} > w_root) begin
                            r_offset <= OffW'({8'd0, r_offset} - w_root);
                            r_state <= S_WAIT;
                        end else begin
                            r_d <= {9'd0, r_offset};
                            r_req.num <= NumW'(w_root - LenW'(r_offset));
                            r_req.den <= DenW'(r_step);
                            r_state <= S_CNT;
                        end
                    end
                end
                S_CNT: if (w_rsp.done) begin
                    // n = quo + 1; new offset = step - rem
                    r_offset <= OffW'(r_step) - OffW'(w_rsp.rem);
                    r_trunc <= w_rsp.quo >= NumW'(MAX_DABS);
                    r_emit  <= (w_rsp.quo >= NumW'(MAX_DABS)) ? KW'(MAX_DABS)
                                                              : KW'(w_rsp.quo + 1);
                    r_k <= '0;
                    r_go <= 1'b0;
                    r_state <= r_vis ? S_DIVX : S_WAIT;
                end
                S_DIVX, S_DIVY, S_DIVP: begin
                    if (!r_go) begin
                        r_go <= 1'b1;
                        r_neg <= w_delta[DeltaW-1];
                        r_req.num <= w_prod;
                        r_req.den <= r_len;
                    end else if (w_rsp.done) begin
                        r_go <= 1'b0;
                        case (r_state)
                            S_DIVX: begin
                                r_cur_x <= CoordW'(w_rq + CoordW'(r_prev_x));
                                r_state <= S_DIVY;
                            end
                            S_DIVY: begin
                                r_cur_y <= CoordW'(w_rq + CoordW'(r_prev_y));
                                r_state <= S_DIVP;
                            end
                            default: begin
                                r_pp <= PresW'(w_rq + (CoordW+1)'(r_prev_p));
                                r_state <= S_ATTR;
                            end
                        endcase
                    end
                end
                S_ATTR: r_state <= S_OUT;
                S_OUT: if (w_out_load) begin
                    r_ox <= r_cur_x; r_oy <= r_cur_y;
                    r_orad <= w_rad_prod[27:13];
                    r_oal <= w_al_prod[18:11];
                    r_olast <= (r_k + KW'(1)) == r_emit;
                    r_otr <= r_trunc;
                    r_k <= r_k + KW'(1);
                    r_d <= r_d + (LenW+1)'(r_step);
                    r_state <= ((r_k + KW'(1)) == r_emit) ? S_WAIT : S_DIVX;
                end
                S_WAIT: begin
                    r_prev_x <= r_new_x; r_prev_y <= r_new_y; r_prev_p <= r_new_p;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign w_sq_start = (r_state == S_SQRT) && (r_ph == 2'd2);
    assign w_sq_val   = r_sqsum;

    assign o_valid          = r_ovalid;
    assign o_dab_x          = r_ox;
    assign o_dab_y          = r_oy;
    assign o_dab_radius     = r_orad;
    assign o_dab_alpha      = r_oal;
    assign o_last_dab       = r_olast;
    assign o_dabs_truncated = r_otr;

`ifndef SYNTHESIS
    // no point is taken while a dab word is pending
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !o_ready) else $error("point taken with dab pending");
    // the dab counter never passes MAX_DABS
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= KW'(MAX_DABS)) else $error("dab count overflow");
    // a truncated segment only occurs with a full dab run
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_dab && o_dabs_truncated) |-> (r_k == KW'(MAX_DABS)))
        else $error("truncated run ended early");
`endif
endmodule

### rtl/sds_div.sv
module sds_div
    import sds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    // restoring divider, one quotient bit a cycle
    logic [NumW-1:0] r_quo, n_quo;
    logic [DenW:0]   r_rem, n_rem;
    logic [DenW-1:0] r_den, n_den;
    logic [5:0]      r_cnt, n_cnt;
    logic            r_busy, n_busy, r_done, n_done;
    logic [DenW:0]   w_trial;

    always_comb begin
        n_quo = r_quo; n_rem = r_rem; n_den = r_den;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        w_trial = {r_rem[DenW-1:0], r_quo[NumW-1]};
        if (i_req.start) begin
            n_quo = i_req.num; n_rem = '0; n_den = i_req.den;
            n_cnt = 6'(NumW); n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_quo = {r_quo[NumW-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[NumW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_quo <= n_quo; r_rem <= n_rem; r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem[DenW-1:0];
endmodule

### rtl/sds_sqrt.sv
module sds_sqrt
    import sds_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [SqW-1:0]  i_val,
    output logic            o_done,
    output logic [LenW-1:0] o_root
);
    // digit-by-digit square root, one result bit a cycle
    localparam int Steps = SqW / 2;
    logic [SqW-1:0]  r_val, n_val;
    logic [LenW+1:0] r_rem, n_rem;
    logic [LenW-1:0] r_root, n_root;
    logic [4:0]      r_cnt, n_cnt;
    logic            r_busy, n_busy, r_done, n_done;
    logic [LenW+1:0] w_trial, w_sub;

    always_comb begin
        n_val = r_val; n_rem = r_rem; n_root = r_root;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        w_trial = {r_rem[LenW-1:0], r_val[SqW-1:SqW-2]};
        w_sub   = {r_root, 2'b01};
        if (i_start) begin
            n_val = i_val; n_rem = '0; n_root = '0;
            n_cnt = 5'(Steps); n_busy = 1'b1;
        end else if (r_busy) begin
            n_val = {r_val[SqW-3:0], 2'b00};
            if (w_trial >= w_sub) begin
                n_rem  = w_trial - w_sub;
                n_root = {r_root[LenW-2:0], 1'b1};
            end else begin
                n_rem  = w_trial;
                n_root = {r_root[LenW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_val <= n_val; r_rem <= n_rem; r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

### tb/sv/tb_stroke_dab_spacer_unit.sv
module tb_stroke_dab_spacer_unit;
    import sds_pkg::*;

    // one polyline point as driven on the input channel
    typedef struct {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic [PresW-1:0]         p;
        logic                     ns;
        logic                     vis;
    } t_point;

    // one dab word as seen on the output channel
    typedef struct {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic [14:0]              radius;
        logic [7:0]               alpha;
        logic                     last;
        logic                     trunc;
    } t_dab;

    localparam int MaxDabs = 64;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [0:0]               i_cfg_idx = RegPenWidth;
    logic [RegW-1:0]          i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic signed [CoordW-1:0] i_point_x = '0;
    logic signed [CoordW-1:0] i_point_y = '0;
    logic [PresW-1:0]         i_point_pressure = '0;
    logic                     i_new_stroke = 1'b0;
    logic                     i_visible = 1'b0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [CoordW-1:0] o_dab_x;
    logic signed [CoordW-1:0] o_dab_y;
    logic [14:0]              o_dab_radius;
    logic [7:0]               o_dab_alpha;
    logic                     o_last_dab;
    logic                     o_dabs_truncated;

    stroke_dab_spacer_unit #(.MAX_DABS(MaxDabs)) DUT (.*);

    // 4 time unit clock period
    always #2 i_clk = ~i_clk;

    // words waiting for the driver, and dabs waiting for the monitor
    t_point pending_points[$];
    t_dab   expected_dabs[$];

    int n_points_sent = 0;
    int n_points_popped = 0;
    int n_dabs_checked = 0;
    int n_mismatches = 0;
    int n_settings = 0;
    bit no_stalls = 1'b0;   // when set, neither side idles

    // predictor copy of the block's registers and state
    int unsigned mdl_pen = 256;
    int unsigned mdl_step = 26;
    longint      mdl_px = 0;
    longint      mdl_py = 0;
    longint      mdl_pp = 0;
    longint      mdl_off = 0;
    bit          mdl_have = 1'b0;

    // bit-serial integer square root, floor
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // num/den rounded to nearest, ties away from zero
    function automatic longint round_div(longint num, longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    // advance the spacing state for one point and queue the dabs it yields
    task automatic plan_dabs(t_point pt);
        longint px, py, pp, dx, dy, dp, seg_len, stp, off, n, emit, d;
        longint qx, qy, qp;
        bit trunc;
        t_dab dab;
        px = pt.x;
        py = pt.y;
        pp = (pt.p > FullPressure) ? FullPressure : pt.p;
        if (pt.ns || !mdl_have) begin
            mdl_have = 1'b1;
            mdl_off = 0;
        end else begin
            dx = px - mdl_px;
            dy = py - mdl_py;
            dp = pp - mdl_pp;
            seg_len = longint'(floor_sqrt(dx * dx + dy * dy));
            stp = (mdl_step == 0) ? 1 : mdl_step;
            off = mdl_off;
            // zero-length segment keeps the offset
            if (seg_len > 0) begin
                if (off > seg_len) begin
                    mdl_off = off - seg_len;
                end else begin
                    n = (seg_len - off) / stp + 1;
                    mdl_off = off + n * stp - seg_len;
                    trunc = n > MaxDabs;
                    emit = trunc ? MaxDabs : n;
                    if (pt.vis) begin
                        for (longint k = 0; k < emit; k++) begin
                            d = off + k * stp;
                            qx = mdl_px + round_div(dx * d, seg_len);
                            qy = mdl_py + round_div(dy * d, seg_len);
                            qp = mdl_pp + round_div(dp * d, seg_len);
                            dab.x = qx[CoordW-1:0];
                            dab.y = qy[CoordW-1:0];
                            dab.radius = 15'((longint'(mdl_pen) * (FullPressure + qp)) >> 13);
                            dab.alpha = 8'((255 * qp) >> 11);
                            dab.last = (k + 1 == emit);
                            dab.trunc = trunc;
                            expected_dabs.push_back(dab);
                        end
                    end
                end
            end
        end
        mdl_px = px;
        mdl_py = py;
        mdl_pp = pp;
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_stalls) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // driver: presents queued points, predicts each one on acceptance
    int send_gap = 0;
    t_point cur_point;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                plan_dabs(cur_point);
                n_points_sent++;
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_points.size() > 0) begin
                    cur_point = pending_points.pop_front();
                    n_points_popped++;
                    i_point_x <= cur_point.x;
                    i_point_y <= cur_point.y;
                    i_point_pressure <= cur_point.p;
                    i_new_stroke <= cur_point.ns;
                    i_visible <= cur_point.vis;
                    i_valid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each taken dab word against the oldest prediction
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_dab want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_dabs.size() == 0) begin
                    n_mismatches++;
                    if (n_mismatches <= 10)
                        $display("unexpected dab word: x=%0d y=%0d r=%0d a=%0d",
                                 o_dab_x, o_dab_y, o_dab_radius, o_dab_alpha);
                end else begin
                    want = expected_dabs.pop_front();
                    n_dabs_checked++;
                    if (o_dab_x !== want.x || o_dab_y !== want.y ||
                        o_dab_radius !== want.radius || o_dab_alpha !== want.alpha ||
                        o_last_dab !== want.last || o_dabs_truncated !== want.trunc) begin
                        n_mismatches++;
                        if (n_mismatches <= 10) begin
                            $display("dab mismatch, expected x=%0d y=%0d r=%0d a=%0d l=%0b t=%0b",
                                     want.x, want.y, want.radius, want.alpha,
                                     want.last, want.trunc);
                            $display("               actual x=%0d y=%0d r=%0d a=%0d l=%0b t=%0b",
                                     o_dab_x, o_dab_y, o_dab_radius, o_dab_alpha,
                                     o_last_dab, o_dabs_truncated);
                        end
                    end
                end
            end
            // receiver stalls
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_ready <= 1'b0;
            end else begin
                stall_left <= pick_gap();
                i_ready <= 1'b1;
            end
        end
    end

    function automatic t_point mk_point(int x, int y, int p, bit ns, bit vis);
        t_point pt;
        pt.x = x[CoordW-1:0];
        pt.y = y[CoordW-1:0];
        pt.p = p[PresW-1:0];
        pt.ns = ns;
        pt.vis = vis;
        return pt;
    endfunction

    // random pressure, biased toward the ends and the saturation range
    function automatic int rand_pressure();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return FullPressure;
            2: return $urandom_range(FullPressure + 1, 4095);
            default: return $urandom_range(0, FullPressure);
        endcase
    endfunction

    // a well-formed stroke with random content, segments scaled by span
    task automatic add_stroke(int span, int npts);
        int cx, cy;
        cx = $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
        cy = $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
        pending_points.push_back(mk_point(cx, cy, rand_pressure(), 1'b1, 1'b1));
        for (int i = 0; i < npts; i++) begin
            case ($urandom_range(0, 9))
                0: ;   // repeat the point, zero length
                1: cx += $urandom_range(0, 1);
                default: begin
                    cx += $urandom_range(0, 2 * span) - span;
                    cy += $urandom_range(0, 2 * span) - span;
                end
            endcase
            cx = $signed(cx << 8) >>> 8;
            cy = $signed(cy << 8) >>> 8;
            pending_points.push_back(mk_point(cx, cy, rand_pressure(),
                                              $urandom_range(0, 19) == 0,
                                              $urandom_range(0, 4) != 0));
        end
    endtask

    // blocks until every queued word is taken and every dab is back,
    // then lets a segment without dabs finish
    task automatic wait_quiet();
        while (pending_points.size() > 0 || i_valid || expected_dabs.size() > 0 ||
               n_points_sent != n_points_popped)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[RegW-1:0];
        if (idx == RegPenWidth) mdl_pen = val & 16'hFFFF;
        else mdl_step = val & 16'hFFFF;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int unsigned pen, int unsigned stp, int span, int n_strokes);
        write_reg(RegPenWidth, pen);
        write_reg(RegDabStep, stp);
        n_settings++;
        for (int s = 0; s < n_strokes; s++)
            add_stroke(span, $urandom_range(3, 7));
        wait_quiet();
    endtask

    initial begin
        int hi, lo;
        hi = 8388607;
        lo = -8388608;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first point after reset without new_stroke still starts a stroke
        pending_points.push_back(mk_point(0, 0, 0, 1'b0, 1'b1));
        pending_points.push_back(mk_point(100, 0, FullPressure, 1'b0, 1'b1));
        pending_points.push_back(mk_point(100, 100, 4095, 1'b0, 1'b1));   // saturates
        pending_points.push_back(mk_point(100, 100, 500, 1'b0, 1'b1));    // zero length
        pending_points.push_back(mk_point(-60, 180, 1000, 1'b0, 1'b0));   // hidden
        pending_points.push_back(mk_point(-59, 180, 1200, 1'b0, 1'b1));   // offset beyond segment
        pending_points.push_back(mk_point(-30, 150, 0, 1'b0, 1'b1));
        pending_points.push_back(mk_point(lo, lo, 4095, 1'b1, 1'b1));
        pending_points.push_back(mk_point(lo + 300, lo + 50, 0, 1'b0, 1'b1));
        pending_points.push_back(mk_point(hi, hi, 2047, 1'b1, 1'b1));
        pending_points.push_back(mk_point(hi - 200, hi, 1, 1'b0, 1'b1));
        pending_points.push_back(mk_point(hi - 2280, hi - 7, 2048, 1'b0, 1'b1)); // truncated
        pending_points.push_back(mk_point(hi - 2280, hi - 2100, 300, 1'b0, 1'b0));
        pending_points.push_back(mk_point(hi - 2200, hi - 2100, 3000, 1'b0, 1'b1));
        wait_quiet();   // sender holds off until every dab is back

        // zero step counts as one
        write_reg(RegDabStep, 0);
        pending_points.push_back(mk_point(5, 5, 100, 1'b1, 1'b1));
        pending_points.push_back(mk_point(9, 8, 2000, 1'b0, 1'b1));
        pending_points.push_back(mk_point(4, 8, 700, 1'b0, 1'b1));
        wait_quiet();

        // random phases across register settings, extremes included
        run_phase(256, 26, 120, 6);
        no_stalls = 1'b1;
        run_phase(16'hFFFF, 16'hFFFF, 200000, 6);
        no_stalls = 1'b0;
        run_phase(0, 1, 6, 6);
        run_phase($urandom_range(0, 16'hFFFF), 0, 5, 5);
        run_phase($urandom_range(0, 16'hFFFF), $urandom_range(20, 300), 900, 5);
        run_phase($urandom_range(0, 16'hFFFF), $urandom_range(2, 40), 150, 6);

        $display("covered %0d points and %0d dabs over %0d register settings",
                 n_points_sent, n_dabs_checked, n_settings + 2);
        if (n_mismatches == 0 && expected_dabs.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d dabs never seen",
                     n_mismatches, expected_dabs.size());
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(4 * 40_000_000);
        $display("timeout");
        $display("Test completed with failures");
        $finish;
    end

endmodule
